[rtl/rgbhsv_pkg.sv]
// Shared constants, types and payload structures of the RGB to HSV converter.
package rgbhsv_pkg;

    localparam int COMPONENT_BITS = 8;
    localparam int DIV_BITS       = 16;
    localparam int DIV_STEPS      = 4;
    localparam int DIV_STAGES     = DIV_BITS / DIV_STEPS;
    localparam int HDEN_W         = COMPONENT_BITS + 3;
    localparam int S_TDATA_W      = ((3 * COMPONENT_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((2 * DIV_BITS + COMPONENT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        MAX_RED   = 2'b00,
        MAX_GREEN = 2'b01,
        MAX_BLUE  = 2'b10
    } max_sel_t;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] red;
        logic [COMPONENT_BITS-1:0] green;
        logic [COMPONENT_BITS-1:0] blue;
        logic [COMPONENT_BITS-1:0] value;
        logic [COMPONENT_BITS-1:0] chroma;
        max_sel_t                  max_sel;
    } prep_t;

    typedef struct packed {
        logic [HDEN_W-1:0]         hue_rem;
        logic [HDEN_W-1:0]         hue_den;
        logic [DIV_BITS-1:0]       hue_q;
        logic [COMPONENT_BITS-1:0] sat_rem;
        logic [COMPONENT_BITS-1:0] sat_den;
        logic [DIV_BITS-1:0]       sat_q;
        logic                      hue_zero;
        logic                      sat_zero;
        logic                      sat_full;
        logic [COMPONENT_BITS-1:0] value;
    } div_word_t;

endpackage

[rtl/rgbhsv_prep.sv]
// Two pipeline stages that find max, min and chroma and form the divider operands.
module rgbhsv_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] in_red,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] in_green,
    input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] in_blue,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rgbhsv_pkg::div_word_t                 out_data
);

    localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
    localparam int HW = rgbhsv_pkg::HDEN_W;

    logic                  s1_valid_reg;
    logic                  s1_ready;
    rgbhsv_pkg::prep_t     s1_data_reg;
    rgbhsv_pkg::prep_t     s1_data_next;
    logic                  s2_valid_reg;
    rgbhsv_pkg::div_word_t s2_data_reg;
    rgbhsv_pkg::div_word_t s2_data_next;

    assign s1_ready = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_comb
    begin
        logic [CB-1:0] mn;
        mn = in_red;
        if (in_green < mn)
        begin
            mn = in_green;
        end
        if (in_blue < mn)
        begin
            mn = in_blue;
        end
        s1_data_next.red   = in_red;
        s1_data_next.green = in_green;
        s1_data_next.blue  = in_blue;
        priority if (in_red >= in_green && in_red >= in_blue)
        begin
            s1_data_next.max_sel = rgbhsv_pkg::MAX_RED;
            s1_data_next.value   = in_red;
        end
        else if (in_green >= in_blue)
        begin
            s1_data_next.max_sel = rgbhsv_pkg::MAX_GREEN;
            s1_data_next.value   = in_green;
        end
        else
        begin
            s1_data_next.max_sel = rgbhsv_pkg::MAX_BLUE;
            s1_data_next.value   = in_blue;
        end
        s1_data_next.chroma = s1_data_next.value - mn;
    end

    always_comb
    begin
        logic [HW-1:0] c_w;
        logic [HW-1:0] six_c;
        logic [HW-1:0] r_w;
        logic [HW-1:0] g_w;
        logic [HW-1:0] b_w;
        c_w   = HW'(s1_data_reg.chroma);
        r_w   = HW'(s1_data_reg.red);
        g_w   = HW'(s1_data_reg.green);
        b_w   = HW'(s1_data_reg.blue);
        six_c = (c_w << 2) + (c_w << 1);
        unique case (s1_data_reg.max_sel)
            rgbhsv_pkg::MAX_RED:
            begin
                if (g_w >= b_w)
                begin
                    s2_data_next.hue_rem = g_w - b_w;
                end
                else
                begin
                    s2_data_next.hue_rem = six_c - (b_w - g_w);
                end
            end
            rgbhsv_pkg::MAX_GREEN:
            begin
                s2_data_next.hue_rem = (c_w << 1) + b_w - r_w;
            end
            default:
            begin
                s2_data_next.hue_rem = (c_w << 2) + r_w - g_w;
            end
        endcase
        s2_data_next.hue_den  = six_c;
        s2_data_next.hue_q    = '0;
        s2_data_next.sat_rem  = s1_data_reg.chroma;
        s2_data_next.sat_den  = s1_data_reg.value;
        s2_data_next.sat_q    = '0;
        s2_data_next.hue_zero = (s1_data_reg.chroma == '0);
        s2_data_next.sat_zero = (s1_data_reg.value == '0);
        s2_data_next.sat_full = (s1_data_reg.value != '0)
                                && (s1_data_reg.chroma == s1_data_reg.value);
        s2_data_next.value    = s1_data_reg.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= s1_data_next;
        end
        if (s1_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

endmodule

[rtl/rgbhsv_div_stage.sv]
// One divider pipeline stage that retires several quotient bits of hue and saturation.
module rgbhsv_div_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rgbhsv_pkg::div_word_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rgbhsv_pkg::div_word_t out_data
);

    localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
    localparam int HW = rgbhsv_pkg::HDEN_W;

    logic                  valid_reg;
    rgbhsv_pkg::div_word_t data_reg;
    rgbhsv_pkg::div_word_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [HW:0] h_sh;
        logic [CB:0] s_sh;
        data_next = in_data;
        for (int k = 0; k < rgbhsv_pkg::DIV_STEPS; k++)
        begin
            h_sh = {data_next.hue_rem, 1'b0};
            if (h_sh >= {1'b0, data_next.hue_den})
            begin
                data_next.hue_rem = HW'(h_sh - {1'b0, data_next.hue_den});
                data_next.hue_q   = {data_next.hue_q[rgbhsv_pkg::DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.hue_rem = h_sh[HW-1:0];
                data_next.hue_q   = {data_next.hue_q[rgbhsv_pkg::DIV_BITS-2:0], 1'b0};
            end
            s_sh = {data_next.sat_rem, 1'b0};
            if (s_sh >= {1'b0, data_next.sat_den})
            begin
                data_next.sat_rem = CB'(s_sh - {1'b0, data_next.sat_den});
                data_next.sat_q   = {data_next.sat_q[rgbhsv_pkg::DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.sat_rem = s_sh[CB-1:0];
                data_next.sat_q   = {data_next.sat_q[rgbhsv_pkg::DIV_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTHESIS
    a_hue_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.hue_zero |-> data_reg.hue_rem < data_reg.hue_den)
        else $error("Hue remainder is not below its divisor.");

    a_sat_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.sat_zero && !data_reg.sat_full
        |-> data_reg.sat_rem < data_reg.sat_den)
        else $error("Saturation remainder is not below its divisor.");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("Divider stage lost or changed a stalled word.");
`endif

endmodule

[rtl/rgb_to_hsv_converter.sv]
// Top level of the RGB to HSV converter with stream ports and the output register.
// Stages: an input transfer passes two operand stages, four divider stages of four quotient
// bits each and one output register before its result appears on the master side.
// Throughput: one pixel per cycle; each stage holds its word when the next one is stalled.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module rgb_to_hsv_converter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: red, green, blue.
    input  logic [rgbhsv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0 up: hue, saturation, brightness.
    output logic [rgbhsv_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CB = rgbhsv_pkg::COMPONENT_BITS;
    localparam int DB = rgbhsv_pkg::DIV_BITS;
    localparam int NS = rgbhsv_pkg::DIV_STAGES;

    logic                  stage_valid [NS+1];
    logic                  stage_ready [NS+1];
    rgbhsv_pkg::div_word_t stage_data  [NS+1];

    logic                  out_valid_reg;
    logic                  out_ready;
    logic [DB-1:0]         hue_reg;
    logic [DB-1:0]         hue_next;
    logic [DB-1:0]         sat_reg;
    logic [DB-1:0]         sat_next;
    logic [CB-1:0]         bright_reg;

    rgbhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_red    (s_axis_tdata[CB-1:0]),
        .in_green  (s_axis_tdata[2*CB-1:CB]),
        .in_blue   (s_axis_tdata[3*CB-1:2*CB]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < NS; i++)
    begin : g_div
        rgbhsv_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_ready  (stage_ready[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_ready (stage_ready[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    assign out_ready          = !out_valid_reg || m_axis_tready;
    assign stage_ready[NS]    = out_ready;

    always_comb
    begin
        if (stage_data[NS].hue_zero)
        begin
            hue_next = '0;
        end
        else
        begin
            hue_next = stage_data[NS].hue_q;
        end
        priority if (stage_data[NS].sat_zero)
        begin
            sat_next = '0;
        end
        else if (stage_data[NS].sat_full)
        begin
            sat_next = '1;
        end
        else
        begin
            sat_next = stage_data[NS].sat_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= stage_valid[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && stage_valid[NS])
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= stage_data[NS].value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = rgbhsv_pkg::M_TDATA_W'({bright_reg, sat_reg, hue_reg});

`ifndef SYNTHESIS
    a_black_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && bright_reg == '0 |-> hue_reg == '0 && sat_reg == '0)
        else $error("A black pixel gave nonzero hue or saturation.");

    a_gray_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && sat_reg == '0 |-> hue_reg == '0)
        else $error("A gray pixel gave a nonzero hue.");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("Input not ready although the output register is empty.");
`endif

endmodule
